// ----- sv/marching_cubes_cell_triangulator_macros.svh -----
// assertion macros for the cell triangulator
`ifndef MARCHING_CUBES_CELL_TRIANGULATOR_MACROS_SVH
`define MARCHING_CUBES_CELL_TRIANGULATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MCCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcct assertion failed");
// next-cycle implication, checked out of reset
`define MCCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcct assertion failed");
`else
`define MCCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/mcct_pkg.sv -----
// types, constants and lookup tables shared by the cell triangulator
`default_nettype none
package mcct_pkg;

    localparam int NUM_CORNERS = 8;
    localparam int NUM_EDGES   = 12;
    localparam int MAX_TRI     = 5;
    localparam int VAL_W       = 16;
    localparam int COORD_W     = 32;
    localparam int CUBE_W      = 31;
    localparam int EDGE_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_W         = 32;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = Q_W / DIV_BITS;
    localparam int PROD_W      = VAL_W + CUBE_W;
    localparam int DIVD_W      = PROD_W + 1;
    localparam int TRI_W       = 3;

    localparam logic [EDGE_W-1:0] EDGE_NONE = 4'hf;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_ORIGIN_X  = 3'd1,
        CFG_ORIGIN_Y  = 3'd2,
        CFG_ORIGIN_Z  = 3'd3,
        CFG_CUBE_SIZE = 3'd4
    } t_cfg_idx;

    // control that travels with one triangle
    typedef struct packed {
        logic valid;
        logic last;
    } t_tri_ctl;

    // issue status seen by the top level
    typedef struct packed {
        logic             valid;
        logic [TRI_W-1:0] tri_idx;
    } t_iss_stat;

    // first corner of an edge
    function automatic logic [2:0] edge_c1(input logic [EDGE_W-1:0] e);
        logic [2:0] c;
        case (e)
            4'd0, 4'd8:  c = 3'd0;
            4'd1, 4'd9:  c = 3'd1;
            4'd2, 4'd10: c = 3'd2;
            4'd3, 4'd11: c = 3'd3;
            4'd4:        c = 3'd4;
            4'd5:        c = 3'd5;
            4'd6:        c = 3'd6;
            4'd7:        c = 3'd7;
            default:     c = 3'd0;
        endcase
        return c;
    endfunction

    // second corner of an edge
    function automatic logic [2:0] edge_c2(input logic [EDGE_W-1:0] e);
        logic [2:0] c;
        case (e)
            4'd0:        c = 3'd1;
            4'd1:        c = 3'd2;
            4'd2:        c = 3'd3;
            4'd3:        c = 3'd0;
            4'd4, 4'd8:  c = 3'd5 - {2'b00, (e == 4'd8)};
            4'd5, 4'd9:  c = 3'd6 - {2'b00, (e == 4'd9)};
            4'd6, 4'd10: c = 3'd7 - {2'b00, (e == 4'd10)};
            4'd7:        c = 3'd4;
            4'd11:       c = 3'd7;
            default:     c = 3'd0;
        endcase
        return c;
    endfunction

    // corner offset as {z, y, x}
    function automatic logic [2:0] corner_offset(input logic [2:0] c);
        logic [2:0] o;
        case (c)
            3'd0:    o = 3'b000;
            3'd1:    o = 3'b001;
            3'd2:    o = 3'b011;
            3'd3:    o = 3'b010;
            3'd4:    o = 3'b100;
            3'd5:    o = 3'b101;
            3'd6:    o = 3'b111;
            3'd7:    o = 3'b110;
            default: o = 3'b000;
        endcase
        return o;
    endfunction

    // triangle table: edge numbers as nibbles from the top, unused nibbles all ones
    localparam logic [63:0] TRI_TABLE [256] = '{
        64'hffffffffffffffff, 64'h083fffffffffffff, 64'h019fffffffffffff, 64'h183981ffffffffff,
        64'h12afffffffffffff, 64'h08312affffffffff, 64'h92a029ffffffffff, 64'h2832a8a98fffffff,
        64'h3b2fffffffffffff, 64'h0b28b0ffffffffff, 64'h19023bffffffffff, 64'h1b219b98bfffffff,
        64'h3a1ba3ffffffffff, 64'h0a108a8bafffffff, 64'h3903b9ba9fffffff, 64'h98aa8bffffffffff,
        64'h478fffffffffffff, 64'h430734ffffffffff, 64'h019847ffffffffff, 64'h419471731fffffff,
        64'h12a847ffffffffff, 64'h34730412afffffff, 64'h92a902847fffffff, 64'h2a9297273794ffff,
        64'h8473b2ffffffffff, 64'hb47b24204fffffff, 64'h90184723bfffffff, 64'h47b94b9b2921ffff,
        64'h3a13ba784fffffff, 64'h1ba14b1047b4ffff, 64'h47890b9bab03ffff, 64'h47b4b99bafffffff,
        64'h954fffffffffffff, 64'h954083ffffffffff, 64'h054150ffffffffff, 64'h854835315fffffff,
        64'h12a954ffffffffff, 64'h30812a495fffffff, 64'h52a542402fffffff, 64'h2a5325354348ffff,
        64'h95423bffffffffff, 64'h0b208b495fffffff, 64'h05401523bfffffff, 64'h21525828b485ffff,
        64'ha3ba13954fffffff, 64'h4950818a18baffff, 64'h54050b5bab03ffff, 64'h54858aa8bfffffff,
        64'h978579ffffffffff, 64'h930953573fffffff, 64'h078017157fffffff, 64'h153357ffffffffff,
        64'h978957a12fffffff, 64'ha12950530573ffff, 64'h802825857a52ffff, 64'h2a5253357fffffff,
        64'h7957893b2fffffff, 64'h95797292027bffff, 64'h23b018178157ffff, 64'hb21b17715fffffff,
        64'h958857a13a3bffff, 64'h5705097b010aba0f, 64'hba0b03a50807570f, 64'hba57b5ffffffffff,
        64'ha65fffffffffffff, 64'h0835a6ffffffffff, 64'h9015a6ffffffffff, 64'h1831985a6fffffff,
        64'h165261ffffffffff, 64'h165126308fffffff, 64'h965906026fffffff, 64'h598582526328ffff,
        64'h23ba65ffffffffff, 64'hb08b20a65fffffff, 64'h01923b5a6fffffff, 64'h5a61929b298bffff,
        64'h63b653513fffffff, 64'h08b0b50515b6ffff, 64'h3b6036065059ffff, 64'h65969bb98fffffff,
        64'h5a6478ffffffffff, 64'h43047365afffffff, 64'h1905a6847fffffff, 64'ha65197173794ffff,
        64'h612651478fffffff, 64'h125526304347ffff, 64'h847905065026ffff, 64'h739794329596269f,
        64'h3b2784a65fffffff, 64'h5a647242027bffff, 64'h01947823b5a6ffff, 64'h9219b294b7b45a6f,
        64'h8473b53515b6ffff, 64'h51b5b610b7b404bf, 64'h059065036b63847f, 64'h65969b4797b9ffff,
        64'ha4964affffffffff, 64'h4a649a083fffffff, 64'ha01a60640fffffff, 64'h83181686461affff,
        64'h149124264fffffff, 64'h308129249264ffff, 64'h024426ffffffffff, 64'h832824426fffffff,
        64'ha49a64b23fffffff, 64'h08228b49a4a6ffff, 64'h3b201606461affff, 64'h64161a48121b8b1f,
        64'h964936913b63ffff, 64'h8b1810b61914641f, 64'h3b6360064fffffff, 64'h648b68ffffffffff,
        64'h7a678a89afffffff, 64'h0730a709a67affff, 64'ha671a7178180ffff, 64'ha67a71173fffffff,
        64'h126168189867ffff, 64'h269291679093739f, 64'h780706602fffffff, 64'h732672ffffffffff,
        64'h23ba68a89867ffff, 64'h20727b09767a9a7f, 64'h1801781a767a23bf, 64'hb21b17a61671ffff,
        64'h896867916b63136f, 64'h091b67ffffffffff, 64'h7807063b0b60ffff, 64'h7b6fffffffffffff,
        64'h76bfffffffffffff, 64'h308b76ffffffffff, 64'h019b76ffffffffff, 64'h819831b76fffffff,
        64'ha126b7ffffffffff, 64'h12a3086b7fffffff, 64'h2902a96b7fffffff, 64'h6b72a3a83a98ffff,
        64'h723627ffffffffff, 64'h708760620fffffff, 64'h276237019fffffff, 64'h162186198876ffff,
        64'ha76a17137fffffff, 64'ha7617a187108ffff, 64'h03707a0a96a7ffff, 64'h76a7a88a9fffffff,
        64'h684b86ffffffffff, 64'h36b306046fffffff, 64'h86b846901fffffff, 64'h946963931b36ffff,
        64'h6846b82a1fffffff, 64'h12a30b06b046ffff, 64'h4b846b0292a9ffff, 64'ha93a32943b36463f,
        64'h823842462fffffff, 64'h042462ffffffffff, 64'h190234246438ffff, 64'h194142246fffffff,
        64'h8138618466a1ffff, 64'ha10a06604fffffff, 64'h4634386a3039a93f, 64'ha946a4ffffffffff,
        64'h49576bffffffffff, 64'h083495b76fffffff, 64'h50154076bfffffff, 64'hb76834354315ffff,
        64'h954a1276bfffffff, 64'h6b712a083495ffff, 64'h76b54a42a402ffff, 64'h348354325a52b76f,
        64'h723762549fffffff, 64'h954086062687ffff, 64'h362376150540ffff, 64'h628687218485158f,
        64'h954a16176137ffff, 64'h16a176107870954f, 64'h40a4a503a6a737af, 64'h76a7a854a48affff,
        64'h6956b9b89fffffff, 64'h36b063056095ffff, 64'h0b805b01556bffff, 64'h6b3635531fffffff,
        64'h12a95b9b8b56ffff, 64'h0b306b09656912af, 64'hb85b56805a52025f, 64'h6b36352a3a53ffff,
        64'h589528562382ffff, 64'h956960062fffffff, 64'h158180568382628f, 64'h156216ffffffffff,
        64'h13616a386569896f, 64'ha10a06950560ffff, 64'h03856affffffffff, 64'ha56fffffffffffff,
        64'hb5a75bffffffffff, 64'hb5ab75830fffffff, 64'h5b75ab190fffffff, 64'ha75ab7981831ffff,
        64'hb12b71751fffffff, 64'h08312717572bffff, 64'h9759279022b7ffff, 64'h75272b592328982f,
        64'h25a235375fffffff, 64'h820852875a25ffff, 64'h9015a35373a2ffff, 64'h982921872a25752f,
        64'h135375ffffffffff, 64'h087071175fffffff, 64'h903935537fffffff, 64'h987597ffffffffff,
        64'h5845a8ab8fffffff, 64'h5045b05abb30ffff, 64'h01984a8aba45ffff, 64'hab4a45b34941314f,
        64'h2512852b8458ffff, 64'h04b0b345b2b151bf, 64'h0250592b5458b85f, 64'h9452b3ffffffffff,
        64'h25a352345384ffff, 64'h5a2524420fffffff, 64'h3a235a385458019f, 64'h5a2524192942ffff,
        64'h845853351fffffff, 64'h045105ffffffffff, 64'h845853905035ffff, 64'h945fffffffffffff,
        64'h4b749b9abfffffff, 64'h0834979b79abffff, 64'h1ab1b414074bffff, 64'h3143481a474bab4f,
        64'h4b79b492b912ffff, 64'h9749b791b2b1083f, 64'hb74b42240fffffff, 64'hb74b42834324ffff,
        64'h29a279237749ffff, 64'h9a7974a27870207f, 64'h37a3a274a1a040af, 64'h1a2874ffffffffff,
        64'h491417713fffffff, 64'h491417081871ffff, 64'h403743ffffffffff, 64'h487fffffffffffff,
        64'h9a8ab8ffffffffff, 64'h30939bb9afffffff, 64'h01a0a88abfffffff, 64'h31ab3affffffffff,
        64'h12b1b99b8fffffff, 64'h30939b1292b9ffff, 64'h02b80bffffffffff, 64'h32bfffffffffffff,
        64'h23828aa89fffffff, 64'h9a2092ffffffffff, 64'h23828a0181a8ffff, 64'h1a2fffffffffffff,
        64'h138918ffffffffff, 64'h091fffffffffffff, 64'h038fffffffffffff, 64'hffffffffffffffff
    };

endpackage
`default_nettype wire

// ----- sv/mcct_issue.sv -----
// cell intake and triangle sequencer: one triangle issued per cycle
`default_nettype none
module mcct_issue import mcct_pkg::*; #(
    parameter int CELL_COORD_BITS = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic [VAL_W-1:0]                      i_threshold,
    input  wire logic [NUM_CORNERS-1:0][VAL_W-1:0]     i_corners,
    input  wire logic [2:0][CELL_COORD_BITS-1:0]       i_cell,
    output t_tri_ctl                                   o_ctl,
    output logic [2:0][EDGE_W-1:0]                     o_edges,
    output logic [NUM_CORNERS-1:0][VAL_W-1:0]          o_corners,
    output logic [2:0][CELL_COORD_BITS-1:0]            o_cell,
    output t_iss_stat                                  o_stat
);

    logic                                  r_valid;
    logic [TRI_W-1:0]                      r_tri;
    logic [7:0]                            r_ci;
    logic [NUM_CORNERS-1:0][VAL_W-1:0]     r_corners;
    logic [2:0][CELL_COORD_BITS-1:0]       r_cell;
    t_tri_ctl                              r_ctl;
    logic [2:0][EDGE_W-1:0]                r_edges;
    logic [NUM_CORNERS-1:0][VAL_W-1:0]     r_out_corners;
    logic [2:0][CELL_COORD_BITS-1:0]       r_out_cell;

    logic [7:0]  n_ci;
    logic [5:0]  shamt;
    logic [63:0] row_sh;
    logic        here;
    logic        next_none;
    logic        done;
    logic        accept;

    // case index from corners at or below the iso level
    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            n_ci[i] = (i_corners[i] <= i_threshold);
        end
    end

    // current triangle's row slice, 12 bits per triangle
    assign shamt     = {r_tri, 3'b000} + {1'b0, r_tri, 2'b00};
    assign row_sh    = TRI_TABLE[r_ci] << shamt;
    assign here      = r_valid && (row_sh[63:60] != EDGE_NONE);
    assign next_none = (row_sh[51:48] == EDGE_NONE) || (r_tri == TRI_W'(MAX_TRI - 1));
    assign done      = r_valid && (!here || next_none);
    assign o_busy    = r_valid && !done;
    assign accept    = i_start && !o_busy;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tri   <= '0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_tri   <= '0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid) begin
            r_tri   <= r_tri + TRI_W'(1);
        end
    end

    // cell payload held while its triangles are issued
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ci      <= n_ci;
            r_corners <= i_corners;
            r_cell    <= i_cell;
        end
    end

    // issue register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= here;
            r_ctl.last  <= next_none;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edges[0]    <= row_sh[63:60];
        r_edges[1]    <= row_sh[59:56];
        r_edges[2]    <= row_sh[55:52];
        r_out_corners <= r_corners;
        r_out_cell    <= r_cell;
    end

    assign o_ctl          = r_ctl;
    assign o_edges        = r_edges;
    assign o_corners      = r_out_corners;
    assign o_cell         = r_out_cell;
    assign o_stat.valid   = r_valid;
    assign o_stat.tri_idx = r_tri;

endmodule
`default_nettype wire

// ----- sv/mcct_div.sv -----
// three-lane pipelined restoring divider, four quotient bits per stage
`default_nettype none
module mcct_div import mcct_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic [2:0][DIVD_W-1:0]   i_divd,
    input  wire logic [2:0][VAL_W-1:0]    i_den,
    output logic [2:0][Q_W-1:0]           o_quo
);

    logic [2:0][VAL_W-1:0] r_rem [DIV_STEPS+1];
    logic [2:0][Q_W-1:0]   r_low [DIV_STEPS+1];
    logic [2:0][Q_W-1:0]   r_q   [DIV_STEPS+1];
    logic [2:0][VAL_W-1:0] r_den [DIV_STEPS+1];
    logic [2:0]            r_dz  [DIV_STEPS+1];

    logic [2:0][VAL_W-1:0] n_rem [DIV_STEPS+1];
    logic [2:0][Q_W-1:0]   n_low [DIV_STEPS+1];
    logic [2:0][Q_W-1:0]   n_q   [DIV_STEPS+1];

    // stage zero: upper dividend bits start the remainder
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_rem[0][k] <= i_divd[k][DIVD_W-1:Q_W];
            r_low[0][k] <= i_divd[k][Q_W-1:0];
            r_q[0][k]   <= '0;
            r_den[0][k] <= i_den[k];
            r_dz[0][k]  <= (i_den[k] == '0);
        end
    end

    // a few subtract-and-shift steps per stage
    always_comb begin
        logic [VAL_W:0]   t;
        logic [VAL_W-1:0] rem;
        logic [Q_W-1:0]   lo;
        logic [Q_W-1:0]   q;
        t   = '0;
        rem = '0;
        lo  = '0;
        q   = '0;
        n_rem[0] = '0;
        n_low[0] = '0;
        n_q[0]   = '0;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            for (int k = 0; k < 3; k++) begin
                rem = r_rem[s-1][k];
                lo  = r_low[s-1][k];
                q   = r_q[s-1][k];
                for (int b = 0; b < DIV_BITS; b++) begin
                    t  = {rem, lo[Q_W-1]};
                    lo = {lo[Q_W-2:0], 1'b0};
                    if (t >= {1'b0, r_den[s-1][k]}) begin
                        t = t - {1'b0, r_den[s-1][k]};
                        q = {q[Q_W-2:0], 1'b1};
                    end else begin
                        q = {q[Q_W-2:0], 1'b0};
                    end
                    rem = t[VAL_W-1:0];
                end
                n_rem[s][k] = rem;
                n_low[s][k] = lo;
                n_q[s][k]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 1; s <= DIV_STEPS; s++) begin
            r_rem[s] <= n_rem[s];
            r_low[s] <= n_low[s];
            r_q[s]   <= n_q[s];
            r_den[s] <= r_den[s-1];
            r_dz[s]  <= r_dz[s-1];
        end
    end

    // a flat edge places its vertex on the first corner
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_quo[k] = r_dz[DIV_STEPS][k] ? '0 : r_q[DIV_STEPS][k];
        end
    end

endmodule
`default_nettype wire

// ----- sv/mcct_vert.sv -----
// vertex pipeline: edge values, products, division and world placement
`default_nettype none
module mcct_vert import mcct_pkg::*; #(
    parameter int CELL_COORD_BITS = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [VAL_W-1:0]                      i_threshold,
    input  wire logic [2:0][COORD_W-1:0]               i_origin,
    input  wire logic [CUBE_W-1:0]                     i_cube_size,
    input  wire t_tri_ctl                              i_ctl,
    input  wire logic [2:0][EDGE_W-1:0]                i_edges,
    input  wire logic [NUM_CORNERS-1:0][VAL_W-1:0]     i_corners,
    input  wire logic [2:0][CELL_COORD_BITS-1:0]       i_cell,
    output t_tri_ctl                                   o_ctl,
    output logic [2:0][2:0][COORD_W-1:0]               o_vert
);

    localparam int GM_W   = CUBE_W + CELL_COORD_BITS;
    localparam int BASE_W = GM_W + 2;
    localparam int POS_W  = BASE_W + 1;
    localparam int W_W    = POS_W + 1;

    // stage 1: edge end values, distances and directions
    t_tri_ctl                          r1_ctl;
    logic [2:0][VAL_W-1:0]             r1_n;
    logic [2:0][VAL_W-1:0]             r1_d;
    logic [2:0][2:0]                   r1_off;
    logic [2:0][2:0]                   r1_inc;
    logic [2:0][2:0]                   r1_dec;
    logic [2:0][CELL_COORD_BITS-1:0]   r1_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [2:0]       c1;
        logic [2:0]       c2;
        logic [VAL_W-1:0] v1;
        logic [VAL_W-1:0] v2;
        logic [2:0]       o1;
        logic [2:0]       o2;
        for (int k = 0; k < 3; k++) begin
            c1 = edge_c1(i_edges[k]);
            c2 = edge_c2(i_edges[k]);
            v1 = i_corners[c1];
            v2 = i_corners[c2];
            o1 = corner_offset(c1);
            o2 = corner_offset(c2);
            r1_n[k]   <= (i_threshold >= v1) ? (i_threshold - v1) : (v1 - i_threshold);
            r1_d[k]   <= (v2 >= v1) ? (v2 - v1) : (v1 - v2);
            r1_off[k] <= o1;
            r1_inc[k] <= o2 & ~o1;
            r1_dec[k] <= o1 & ~o2;
        end
        r1_cell <= i_cell;
    end

    // stage 2: distance times cell size, cell origin products
    t_tri_ctl                  r2_ctl;
    logic [2:0][PROD_W-1:0]    r2_prod;
    logic [2:0][VAL_W-1:0]     r2_d;
    logic [2:0][2:0]           r2_off;
    logic [2:0][2:0]           r2_inc;
    logic [2:0][2:0]           r2_dec;
    logic [2:0][GM_W-1:0]      r2_gm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_prod[k] <= {{CUBE_W{1'b0}}, r1_n[k]} * {{VAL_W{1'b0}}, i_cube_size};
            r2_gm[k]   <= {{CELL_COORD_BITS{1'b0}}, i_cube_size}
                        * {{CUBE_W{1'b0}}, r1_cell[k]};
        end
        r2_d   <= r1_d;
        r2_off <= r1_off;
        r2_inc <= r1_inc;
        r2_dec <= r1_dec;
    end

    // stage 3: rounding bias and world base per axis
    t_tri_ctl                  r3_ctl;
    logic [2:0][DIVD_W-1:0]    r3_divd;
    logic [2:0][VAL_W-1:0]     r3_d;
    logic [2:0][2:0]           r3_off;
    logic [2:0][2:0]           r3_inc;
    logic [2:0][2:0]           r3_dec;
    logic [2:0][BASE_W-1:0]    r3_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_divd[k] <= {1'b0, r2_prod[k]} + {{(DIVD_W-VAL_W+1){1'b0}}, r2_d[k][VAL_W-1:1]};
            r3_base[k] <= BASE_W'($signed({{(BASE_W-COORD_W){i_origin[k][COORD_W-1]}},
                                           i_origin[k]})
                                + $signed({2'b00, r2_gm[k]}));
        end
        r3_d   <= r2_d;
        r3_off <= r2_off;
        r3_inc <= r2_inc;
        r3_dec <= r2_dec;
    end

    // stage 4: first corner position, division starts alongside
    logic [2:0][Q_W-1:0]            quo;
    t_tri_ctl                       r4_ctl;
    logic [2:0][2:0][POS_W-1:0]     r4_pos;
    logic [2:0][2:0]                r4_inc;
    logic [2:0][2:0]                r4_dec;

    mcct_div u_div (
        .i_clk  (i_clk),
        .i_divd (r3_divd),
        .i_den  (r3_d),
        .o_quo  (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else begin
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                r4_pos[k][a] <= POS_W'($signed({r3_base[a][BASE_W-1], r3_base[a]})
                              + $signed({{(POS_W-CUBE_W){1'b0}},
                                         (r3_off[k][a] ? i_cube_size : CUBE_W'(0))}));
            end
        end
        r4_inc <= r3_inc;
        r4_dec <= r3_dec;
    end

    // delay line matching the divider depth
    t_tri_ctl                       r5_ctl [DIV_STEPS];
    logic [2:0][2:0][POS_W-1:0]     r5_pos [DIV_STEPS];
    logic [2:0][2:0]                r5_inc [DIV_STEPS];
    logic [2:0][2:0]                r5_dec [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r5_ctl[s] <= '0;
            end
        end else begin
            r5_ctl[0] <= r4_ctl;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r5_ctl[s] <= r5_ctl[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r5_pos[0] <= r4_pos;
        r5_inc[0] <= r4_inc;
        r5_dec[0] <= r4_dec;
        for (int s = 1; s < DIV_STEPS; s++) begin
            r5_pos[s] <= r5_pos[s-1];
            r5_inc[s] <= r5_inc[s-1];
            r5_dec[s] <= r5_dec[s-1];
        end
    end

    // final stage: step along the edge and clamp to 32 bits
    t_tri_ctl                       r_out_ctl;
    logic [2:0][2:0][COORD_W-1:0]   r_out_vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else begin
            r_out_ctl <= r5_ctl[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [W_W-1:0] p;
        logic signed [W_W-1:0] st;
        logic signed [W_W-1:0] w;
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                p  = $signed({r5_pos[DIV_STEPS-1][k][a][POS_W-1], r5_pos[DIV_STEPS-1][k][a]});
                st = $signed({{(W_W-Q_W){1'b0}}, quo[k]});
                if (r5_inc[DIV_STEPS-1][k][a]) begin
                    w = p + st;
                end else if (r5_dec[DIV_STEPS-1][k][a]) begin
                    w = p - st;
                end else begin
                    w = p;
                end
                if (w > $signed(W_W'(32'h7fffffff))) begin
                    r_out_vert[k][a] <= 32'h7fffffff;
                end else if (w < $signed({{(W_W-COORD_W){1'b1}}, 32'h80000000})) begin
                    r_out_vert[k][a] <= 32'h80000000;
                end else begin
                    r_out_vert[k][a] <= w[COORD_W-1:0];
                end
            end
        end
    end

    assign o_ctl  = r_out_ctl;
    assign o_vert = r_out_vert;

endmodule
`default_nettype wire

// ----- sv/marching_cubes_cell_triangulator.sv -----
// top level of the marching cubes cell triangulator
//
// One cell is taken on a cycle where i_start is high and o_busy is low:
// eight corner values and the cell's grid index. The block emits up to
// five triangles for it, one per cycle, each for exactly one cycle with
// o_valid high; o_last_triangle marks the final triangle of the cell.
// A cell with no crossing emits nothing.
// A cell holds the issue slot while its triangles are issued; the
// triangle sequencer issues one triangle a cycle, so the next
// cell is taken in the cycle its predecessor issues its last triangle.
// On its way out the first triangle passes issue, three arithmetic stages,
// the divider's entry stage and eight stages of four quotient bits each,
// then the output register. Registers are written through i_cfg_we /
// i_cfg_idx / i_cfg_wdata; the user must write them only while no cell is in
// flight, which the block does not enforce. Reset restores threshold 0x8000,
// origin zero and a cube size of 1.0 and empties the pipeline. The receiver
// cannot stall: every triangle is presented once and must be taken then.
`default_nettype none
`include "marching_cubes_cell_triangulator_macros.svh"
module marching_cubes_cell_triangulator import mcct_pkg::*; #(
    parameter int CELL_COORD_BITS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [COORD_W-1:0]          i_cfg_wdata,
    input  wire logic [VAL_W-1:0]            i_corner_v0,
    input  wire logic [VAL_W-1:0]            i_corner_v1,
    input  wire logic [VAL_W-1:0]            i_corner_v2,
    input  wire logic [VAL_W-1:0]            i_corner_v3,
    input  wire logic [VAL_W-1:0]            i_corner_v4,
    input  wire logic [VAL_W-1:0]            i_corner_v5,
    input  wire logic [VAL_W-1:0]            i_corner_v6,
    input  wire logic [VAL_W-1:0]            i_corner_v7,
    input  wire logic [CELL_COORD_BITS-1:0]  i_cell_x,
    input  wire logic [CELL_COORD_BITS-1:0]  i_cell_y,
    input  wire logic [CELL_COORD_BITS-1:0]  i_cell_z,
    output logic                             o_valid,
    output logic signed [COORD_W-1:0]        o_vert_a_x,
    output logic signed [COORD_W-1:0]        o_vert_a_y,
    output logic signed [COORD_W-1:0]        o_vert_a_z,
    output logic signed [COORD_W-1:0]        o_vert_b_x,
    output logic signed [COORD_W-1:0]        o_vert_b_y,
    output logic signed [COORD_W-1:0]        o_vert_b_z,
    output logic signed [COORD_W-1:0]        o_vert_c_x,
    output logic signed [COORD_W-1:0]        o_vert_c_y,
    output logic signed [COORD_W-1:0]        o_vert_c_z,
    output logic                             o_last_triangle
);

    logic [VAL_W-1:0]          r_threshold;
    logic [2:0][COORD_W-1:0]   r_origin;
    logic [CUBE_W-1:0]         r_cube_size;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'h8000;
            r_origin    <= '0;
            r_cube_size <= 31'h0001_0000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[VAL_W-1:0];
                CFG_ORIGIN_X:  r_origin[0] <= i_cfg_wdata;
                CFG_ORIGIN_Y:  r_origin[1] <= i_cfg_wdata;
                CFG_ORIGIN_Z:  r_origin[2] <= i_cfg_wdata;
                CFG_CUBE_SIZE: r_cube_size <= i_cfg_wdata[CUBE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [NUM_CORNERS-1:0][VAL_W-1:0]   corners;
    logic [2:0][CELL_COORD_BITS-1:0]     cell_idx;
    t_tri_ctl                            iss_ctl;
    logic [2:0][EDGE_W-1:0]              iss_edges;
    logic [NUM_CORNERS-1:0][VAL_W-1:0]   iss_corners;
    logic [2:0][CELL_COORD_BITS-1:0]     iss_cell;
    t_iss_stat                           iss_stat;
    t_tri_ctl                            out_ctl;
    logic [2:0][2:0][COORD_W-1:0]        out_vert;

    assign corners  = {i_corner_v7, i_corner_v6, i_corner_v5, i_corner_v4,
                       i_corner_v3, i_corner_v2, i_corner_v1, i_corner_v0};
    assign cell_idx = {i_cell_z, i_cell_y, i_cell_x};

    // cell intake and triangle issue
    mcct_issue #(
        .CELL_COORD_BITS (CELL_COORD_BITS)
    ) u_issue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_threshold (r_threshold),
        .i_corners   (corners),
        .i_cell      (cell_idx),
        .o_ctl       (iss_ctl),
        .o_edges     (iss_edges),
        .o_corners   (iss_corners),
        .o_cell      (iss_cell),
        .o_stat      (iss_stat)
    );

    // per-triangle vertex pipeline
    mcct_vert #(
        .CELL_COORD_BITS (CELL_COORD_BITS)
    ) u_vert (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_origin    (r_origin),
        .i_cube_size (r_cube_size),
        .i_ctl       (iss_ctl),
        .i_edges     (iss_edges),
        .i_corners   (iss_corners),
        .i_cell      (iss_cell),
        .o_ctl       (out_ctl),
        .o_vert      (out_vert)
    );

    assign o_valid         = out_ctl.valid;
    assign o_last_triangle = out_ctl.last;
    assign o_vert_a_x      = out_vert[0][0];
    assign o_vert_a_y      = out_vert[0][1];
    assign o_vert_a_z      = out_vert[0][2];
    assign o_vert_b_x      = out_vert[1][0];
    assign o_vert_b_y      = out_vert[1][1];
    assign o_vert_b_z      = out_vert[1][2];
    assign o_vert_c_x      = out_vert[2][0];
    assign o_vert_c_y      = out_vert[2][1];
    assign o_vert_c_z      = out_vert[2][2];

    // a taken cell starts at its first triangle
    `MCCT_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_start && !o_busy, iss_stat.valid && (iss_stat.tri_idx == '0))
    // the sequencer never walks past the last table slot
    `MCCT_ASSERT_IMP(a_tri_bound, i_clk, i_rst_n, iss_stat.valid, iss_stat.tri_idx < TRI_W'(MAX_TRI))
    // triangles of one cell leave on consecutive cycles
    `MCCT_ASSERT_NXT(a_tri_burst, i_clk, i_rst_n, o_valid && !o_last_triangle, o_valid)

endmodule
`default_nettype wire
